### rtl/mlex_pkg.sv
// markup lexer package: record layout, lexer modes, token and error codes
// and the small character-class and keyword helper functions
// no dependencies
package mlex_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_RECS = 3;
  localparam logic [15:0] LEN_MAX = 16'hffff;

  localparam logic [1:0] REC_TEXT = 2'd0;
  localparam logic [1:0] REC_DONE = 2'd1;
  localparam logic [1:0] REC_ERROR = 2'd2;

  localparam logic [3:0] KIND_EOF = 4'd0;
  localparam logic [3:0] KIND_IDENT = 4'd1;
  localparam logic [3:0] KIND_STRING = 4'd2;
  localparam logic [3:0] KIND_INT = 4'd3;
  localparam logic [3:0] KIND_TRUE = 4'd4;
  localparam logic [3:0] KIND_FALSE = 4'd5;
  localparam logic [3:0] KIND_HASH = 4'd6;
  localparam logic [3:0] KIND_LPAREN = 4'd7;
  localparam logic [3:0] KIND_RPAREN = 4'd8;
  localparam logic [3:0] KIND_LBRACE = 4'd9;
  localparam logic [3:0] KIND_RBRACE = 4'd10;
  localparam logic [3:0] KIND_EQUALS = 4'd11;

  localparam logic [1:0] ERR_UNTERM = 2'd0;
  localparam logic [1:0] ERR_ESCAPE = 2'd1;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

  // keyword tracker positions: after "t" and after "f", full words at 4 and 9
  localparam logic [3:0] KW_NONE = 4'd0;
  localparam logic [3:0] KW_T = 4'd1;
  localparam logic [3:0] KW_TRUE = 4'd4;
  localparam logic [3:0] KW_F = 4'd5;
  localparam logic [3:0] KW_FALSE = 4'd9;

  typedef enum logic [8:0] {
    M_IDLE    = 9'b000000001,
    M_SLASH   = 9'b000000010,
    M_COMMENT = 9'b000000100,
    M_MINUS   = 9'b000001000,
    M_INT     = 9'b000010000,
    M_IDENT   = 9'b000100000,
    M_STR     = 9'b001000000,
    M_ESC     = 9'b010000000,
    M_ERROR   = 9'b100000000
  } mode_e;

  typedef struct packed {
    logic [1:0]  rtype;
    logic [3:0]  kind;
    logic [7:0]  text;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic [1:0]  err;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [1:0]           count;
    rec_t [MAX_RECS-1:0]  recs;
  } push_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_word_tail(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == "_") || (c == ".") || (c == ",");
  endfunction

  function automatic logic [3:0] punct_kind(logic [7:0] c);
    logic [3:0] k;
    case (c)
      "#":     k = KIND_HASH;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "=":     k = KIND_EQUALS;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] kw_char(logic [3:0] s);
    logic [7:0] ch;
    case (s)
      4'd1:    ch = "r";
      4'd2:    ch = "u";
      4'd3:    ch = "e";
      4'd5:    ch = "a";
      4'd6:    ch = "l";
      4'd7:    ch = "s";
      4'd8:    ch = "e";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [3:0] kw_step(logic [3:0] s, logic [7:0] c);
    logic [7:0] nc;
    nc = kw_char(s);
    return ((nc != 8'd0) && (c == nc)) ? s + 4'd1 : KW_NONE;
  endfunction

  function automatic logic [3:0] word_kind(logic [3:0] s);
    logic [3:0] k;
    case (s)
      KW_TRUE:  k = KIND_TRUE;
      KW_FALSE: k = KIND_FALSE;
      default:  k = KIND_IDENT;
    endcase
    return k;
  endfunction

  function automatic rec_t mk_rec(logic [1:0] rtype, logic [3:0] kind, logic [7:0] text,
                                  logic [15:0] line, logic [15:0] column,
                                  logic [15:0] length, logic [1:0] err);
    rec_t r;
    r.rtype  = rtype;
    r.kind   = kind;
    r.text   = text;
    r.line   = line;
    r.column = column;
    r.length = length;
    r.err    = err;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

### rtl/markup_lexer_top.sv
// markup lexer top level: byte input channel, record output channel
// depends on mlex_pkg, mlex_core and mlex_queue
//
// One source byte per accepted word; each byte is lexed in the cycle it is
// accepted and yields zero to three records (token text bytes, token complete,
// error), which go into a four-entry record queue. The output channel drains
// one record per cycle, so with no output stall the block takes a byte every
// cycle while each byte yields at most one record, and a byte with two or three
// records stalls the input while the queue drains. The input stalls
// while more than one record is queued. Line and column are POSITION_BITS wide
// internally and reported in their low 16 bits.
module markup_lexer_top #(
  parameter int POSITION_BITS = mlex_pkg::POSITION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  record_type_o,
  output logic [3:0]  token_kind_o,
  output logic [7:0]  text_byte_o,
  output logic [15:0] start_line_o,
  output logic [15:0] start_column_o,
  output logic [15:0] text_length_o,
  output logic [1:0]  error_code_o,
  output logic        last_o
);

  mlex_pkg::push_t push;
  mlex_pkg::rec_t  head;
  logic            room;
  logic            accept;
  logic            pop;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;
  assign pop        = out_valid_o && !out_stall_i;

  mlex_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .char_byte_i   (char_byte_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push)
  );

  mlex_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .room_o  (room),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  assign record_type_o  = head.rtype;
  assign token_kind_o   = head.kind;
  assign text_byte_o    = head.text;
  assign start_line_o   = head.line;
  assign start_column_o = head.column;
  assign text_length_o  = head.length;
  assign error_code_o   = head.err;
  assign last_o         = head.last;

endmodule

### rtl/mlex_core.sv
// markup lexer core: mode and position registers and the per-byte step
// that yields up to three records for the record queue
// depends on mlex_pkg
module mlex_core #(
  parameter int POSITION_BITS = mlex_pkg::POSITION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         char_byte_i,
  input  logic               end_of_text_i,
  output mlex_pkg::push_t    push_o
);

  localparam int PW = (POSITION_BITS > 16) ? POSITION_BITS : 16;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  function automatic logic [15:0] pos16(logic [POSITION_BITS-1:0] v);
    logic [PW-1:0] w;
    w = PW'(v);
    return w[15:0];
  endfunction

  mlex_pkg::mode_e           mode_q, mode_d;
  logic [POSITION_BITS-1:0]  cur_line_q, cur_line_d;
  logic [POSITION_BITS-1:0]  cur_col_q, cur_col_d;
  logic [POSITION_BITS-1:0]  tok_line_q, tok_line_d;
  logic [POSITION_BITS-1:0]  tok_col_q, tok_col_d;
  logic [15:0]               tok_len_q, tok_len_d;
  logic [3:0]                kw_q, kw_d;

  mlex_pkg::rec_t [mlex_pkg::MAX_RECS-1:0] recs;
  logic [1:0]  n;
  logic        is_end;
  logic        do_idle;
  logic [7:0]  c;
  logic [7:0]  esc;
  logic [3:0]  pk;

  always_comb begin
    c         = char_byte_i;
    is_end    = end_of_text_i || (c == 8'd0);
    mode_d    = mode_q;
    cur_line_d = cur_line_q;
    cur_col_d = cur_col_q;
    tok_line_d = tok_line_q;
    tok_col_d = tok_col_q;
    tok_len_d = tok_len_q;
    kw_d      = kw_q;
    recs      = '0;
    n         = 2'd0;
    do_idle   = 1'b0;
    esc       = 8'd0;
    pk        = mlex_pkg::punct_kind(c);

    if (is_end) begin
      case (mode_q)
        mlex_pkg::M_IDENT, mlex_pkg::M_INT: begin
          recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_DONE,
                      (mode_q == mlex_pkg::M_INT) ? mlex_pkg::KIND_INT
                                                  : mlex_pkg::word_kind(kw_q),
                      8'd0, pos16(tok_line_q), pos16(tok_col_q), tok_len_q,
                      mlex_pkg::ERR_UNTERM);
          n = n + 2'd1;
          recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_DONE, mlex_pkg::KIND_EOF, 8'd0,
                      pos16(cur_line_q), pos16(cur_col_q), 16'd0, mlex_pkg::ERR_UNTERM);
          n = n + 2'd1;
        end
        mlex_pkg::M_SLASH, mlex_pkg::M_MINUS: begin
          recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_ERROR, mlex_pkg::KIND_EOF, 8'd0,
                      pos16(tok_line_q), pos16(tok_col_q), 16'd0,
                      mlex_pkg::ERR_UNEXPECTED);
          n = n + 2'd1;
        end
        mlex_pkg::M_STR, mlex_pkg::M_ESC: begin
          recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_ERROR, mlex_pkg::KIND_EOF, 8'd0,
                      pos16(tok_line_q), pos16(tok_col_q), 16'd0, mlex_pkg::ERR_UNTERM);
          n = n + 2'd1;
        end
        mlex_pkg::M_ERROR: begin
        end
        default: begin
          recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_DONE, mlex_pkg::KIND_EOF, 8'd0,
                      pos16(cur_line_q), pos16(cur_col_q), 16'd0, mlex_pkg::ERR_UNTERM);
          n = n + 2'd1;
        end
      endcase
      mode_d     = mlex_pkg::M_IDLE;
      cur_line_d = POS_ONE;
      cur_col_d  = POS_ONE;
      tok_line_d = POS_ONE;
      tok_col_d  = POS_ONE;
      tok_len_d  = 16'd0;
      kw_d       = mlex_pkg::KW_NONE;
    end else if (mode_q != mlex_pkg::M_ERROR) begin
      case (mode_q)
        mlex_pkg::M_COMMENT: begin
          if (c == 8'd10) mode_d = mlex_pkg::M_IDLE;
        end
        mlex_pkg::M_SLASH: begin
          if (c == "/") begin
            mode_d = mlex_pkg::M_COMMENT;
          end else begin
            recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_ERROR, mlex_pkg::KIND_EOF, 8'd0,
                        pos16(tok_line_q), pos16(tok_col_q), 16'd0,
                        mlex_pkg::ERR_UNEXPECTED);
            n = n + 2'd1;
            mode_d = mlex_pkg::M_ERROR;
          end
        end
        mlex_pkg::M_MINUS: begin
          if (mlex_pkg::is_digit(c)) begin
            mode_d = mlex_pkg::M_INT;
            if (tok_len_d != mlex_pkg::LEN_MAX) tok_len_d = tok_len_d + 16'd1;
            recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_TEXT, mlex_pkg::KIND_INT, "-",
                        pos16(tok_line_q), pos16(tok_col_q), tok_len_d,
                        mlex_pkg::ERR_UNTERM);
            n = n + 2'd1;
            if (tok_len_d != mlex_pkg::LEN_MAX) tok_len_d = tok_len_d + 16'd1;
            recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_TEXT, mlex_pkg::KIND_INT, c,
                        pos16(tok_line_q), pos16(tok_col_q), tok_len_d,
                        mlex_pkg::ERR_UNTERM);
            n = n + 2'd1;
          end else begin
            recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_ERROR, mlex_pkg::KIND_EOF, 8'd0,
                        pos16(tok_line_q), pos16(tok_col_q), 16'd0,
                        mlex_pkg::ERR_UNEXPECTED);
            n = n + 2'd1;
            mode_d = mlex_pkg::M_ERROR;
          end
        end
        mlex_pkg::M_STR: begin
          if (c == "\"") begin
            recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_DONE, mlex_pkg::KIND_STRING, 8'd0,
                        pos16(tok_line_q), pos16(tok_col_q), tok_len_q,
                        mlex_pkg::ERR_UNTERM);
            n = n + 2'd1;
            mode_d = mlex_pkg::M_IDLE;
          end else if (c == "\\") begin
            mode_d = mlex_pkg::M_ESC;
          end else begin
            if (tok_len_d != mlex_pkg::LEN_MAX) tok_len_d = tok_len_d + 16'd1;
            recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_TEXT, mlex_pkg::KIND_STRING, c,
                        pos16(tok_line_q), pos16(tok_col_q), tok_len_d,
                        mlex_pkg::ERR_UNTERM);
            n = n + 2'd1;
          end
        end
        mlex_pkg::M_ESC: begin
          case (c)
            "n":     esc = 8'd10;
            "r":     esc = 8'd13;
            "t":     esc = 8'd9;
            "\\":    esc = c;
            "\"":    esc = c;
            default: esc = 8'd0;
          endcase
          if (esc != 8'd0) begin
            mode_d = mlex_pkg::M_STR;
            if (tok_len_d != mlex_pkg::LEN_MAX) tok_len_d = tok_len_d + 16'd1;
            recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_TEXT, mlex_pkg::KIND_STRING, esc,
                        pos16(tok_line_q), pos16(tok_col_q), tok_len_d,
                        mlex_pkg::ERR_UNTERM);
            n = n + 2'd1;
          end else begin
            recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_ERROR, mlex_pkg::KIND_EOF, 8'd0,
                        pos16(cur_line_q), pos16(cur_col_q), 16'd0,
                        mlex_pkg::ERR_ESCAPE);
            n = n + 2'd1;
            mode_d = mlex_pkg::M_ERROR;
          end
        end
        mlex_pkg::M_INT: begin
          if (mlex_pkg::is_digit(c)) begin
            if (tok_len_d != mlex_pkg::LEN_MAX) tok_len_d = tok_len_d + 16'd1;
            recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_TEXT, mlex_pkg::KIND_INT, c,
                        pos16(tok_line_q), pos16(tok_col_q), tok_len_d,
                        mlex_pkg::ERR_UNTERM);
            n = n + 2'd1;
          end else begin
            recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_DONE, mlex_pkg::KIND_INT, 8'd0,
                        pos16(tok_line_q), pos16(tok_col_q), tok_len_q,
                        mlex_pkg::ERR_UNTERM);
            n = n + 2'd1;
            mode_d  = mlex_pkg::M_IDLE;
            do_idle = 1'b1;
          end
        end
        mlex_pkg::M_IDENT: begin
          if (mlex_pkg::is_word_tail(c)) begin
            kw_d = mlex_pkg::kw_step(kw_q, c);
            if (tok_len_d != mlex_pkg::LEN_MAX) tok_len_d = tok_len_d + 16'd1;
            recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_TEXT, mlex_pkg::KIND_IDENT, c,
                        pos16(tok_line_q), pos16(tok_col_q), tok_len_d,
                        mlex_pkg::ERR_UNTERM);
            n = n + 2'd1;
          end else begin
            recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_DONE, mlex_pkg::word_kind(kw_q), 8'd0,
                        pos16(tok_line_q), pos16(tok_col_q), tok_len_q,
                        mlex_pkg::ERR_UNTERM);
            n = n + 2'd1;
            mode_d  = mlex_pkg::M_IDLE;
            kw_d    = mlex_pkg::KW_NONE;
            do_idle = 1'b1;
          end
        end
        mlex_pkg::M_IDLE: begin
          do_idle = 1'b1;
        end
        default: begin
          mode_d = mlex_pkg::M_ERROR;
        end
      endcase

      // byte seen between tokens, or the byte that cut a word or number short
      if (do_idle && !mlex_pkg::is_space(c)) begin
        if (pk != mlex_pkg::KIND_EOF || mlex_pkg::is_digit(c) || mlex_pkg::is_alpha(c) ||
            c == "_" || c == "/" || c == "-" || c == "\"") begin
          tok_line_d = cur_line_q;
          tok_col_d  = cur_col_q;
          tok_len_d  = 16'd0;
        end
        if (pk != mlex_pkg::KIND_EOF) begin
          mode_d = mlex_pkg::M_IDLE;
          recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_TEXT, pk, c, pos16(cur_line_q),
                      pos16(cur_col_q), 16'd1, mlex_pkg::ERR_UNTERM);
          n = n + 2'd1;
          recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_DONE, pk, 8'd0, pos16(cur_line_q),
                      pos16(cur_col_q), 16'd1, mlex_pkg::ERR_UNTERM);
          n = n + 2'd1;
          tok_len_d = 16'd1;
        end else if (c == "/") begin
          mode_d = mlex_pkg::M_SLASH;
        end else if (c == "-") begin
          mode_d = mlex_pkg::M_MINUS;
        end else if (mlex_pkg::is_digit(c)) begin
          mode_d = mlex_pkg::M_INT;
          tok_len_d = 16'd1;
          recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_TEXT, mlex_pkg::KIND_INT, c,
                      pos16(cur_line_q), pos16(cur_col_q), 16'd1, mlex_pkg::ERR_UNTERM);
          n = n + 2'd1;
        end else if (mlex_pkg::is_alpha(c) || c == "_") begin
          mode_d = mlex_pkg::M_IDENT;
          if (c == "t") kw_d = mlex_pkg::KW_T;
          else if (c == "f") kw_d = mlex_pkg::KW_F;
          else kw_d = mlex_pkg::KW_NONE;
          tok_len_d = 16'd1;
          recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_TEXT, mlex_pkg::KIND_IDENT, c,
                      pos16(cur_line_q), pos16(cur_col_q), 16'd1, mlex_pkg::ERR_UNTERM);
          n = n + 2'd1;
        end else if (c == "\"") begin
          mode_d = mlex_pkg::M_STR;
        end else begin
          recs[n] = mlex_pkg::mk_rec(mlex_pkg::REC_ERROR, mlex_pkg::KIND_EOF, 8'd0,
                      pos16(cur_line_q), pos16(cur_col_q), 16'd0,
                      mlex_pkg::ERR_UNEXPECTED);
          n = n + 2'd1;
          mode_d = mlex_pkg::M_ERROR;
        end
      end

      if (c == 8'd10) begin
        if (cur_line_q != POS_MAX) cur_line_d = cur_line_q + POS_ONE;
        cur_col_d = POS_ONE;
      end else if (cur_col_q != POS_MAX) begin
        cur_col_d = cur_col_q + POS_ONE;
      end
    end

    if (n != 2'd0) recs[n - 2'd1].last = 1'b1;

    push_o.count = accept_i ? n : 2'd0;
    push_o.recs  = recs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= mlex_pkg::M_IDLE;
      cur_line_q <= POS_ONE;
      cur_col_q  <= POS_ONE;
      tok_line_q <= POS_ONE;
      tok_col_q  <= POS_ONE;
      tok_len_q  <= 16'd0;
      kw_q       <= mlex_pkg::KW_NONE;
    end else if (accept_i) begin
      mode_q     <= mode_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      tok_len_q  <= tok_len_d;
      kw_q       <= kw_d;
    end
  end

endmodule

### rtl/mlex_queue.sv
// markup lexer record queue: takes up to three records per cycle from the
// core and hands one record per cycle to the output channel while it does not stall
// depends on mlex_pkg
module mlex_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mlex_pkg::push_t   push_i,
  input  logic              pop_i,
  output logic              room_o,
  output logic              valid_o,
  output mlex_pkg::rec_t    head_o
);

  localparam int AW = $clog2(mlex_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(mlex_pkg::QUEUE_DEPTH + 1);

  mlex_pkg::rec_t  mem_q [mlex_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]   offs [mlex_pkg::QUEUE_DEPTH];

  always_comb begin
    for (int i = 0; i < mlex_pkg::QUEUE_DEPTH; i++) begin
      offs[i] = AW'(i) - wr_ptr_q;
    end
    wr_ptr_d = wr_ptr_q + AW'(push_i.count);
    rd_ptr_d = rd_ptr_q + AW'(pop_i);
    cnt_d    = cnt_q + CW'(push_i.count) - CW'(pop_i);
  end

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  // room for a full burst of records from one byte
  assign room_o  = (cnt_q <= CW'(mlex_pkg::QUEUE_DEPTH - mlex_pkg::MAX_RECS));

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < mlex_pkg::QUEUE_DEPTH; i++) begin
      if (offs[i] < AW'(push_i.count)) mem_q[i] <= push_i.recs[offs[i][1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### bench/markup_lexer_checker.sv
// markup lexer checker: watches the byte and record channels, works out the
// records of every accepted source byte and compares them in order
// depends on mlex_pkg for record, kind, error and lexer mode codes
`timescale 1ns / 1ps
module markup_lexer_checker #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  char_byte_i,
  input  logic        end_of_text_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  record_type_i,
  input  logic [3:0]  token_kind_i,
  input  logic [7:0]  text_byte_i,
  input  logic [15:0] start_line_i,
  input  logic [15:0] start_column_i,
  input  logic [15:0] text_length_i,
  input  logic [1:0]  error_code_i,
  input  logic        last_i,
  output int          pending_o,
  output int          errors_o
);

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [POSITION_BITS-1:0] POS_SAT = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  typedef struct packed {
    logic [1:0]  rtype;
    logic [3:0]  kind;
    logic [7:0]  text;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic [1:0]  err;
    logic        last;
  } lex_rec_t;

  mlex_pkg::mode_e          lex_state;
  logic [POSITION_BITS-1:0] cur_line;
  logic [POSITION_BITS-1:0] cur_col;
  logic [POSITION_BITS-1:0] tok_line;
  logic [POSITION_BITS-1:0] tok_col;
  logic [15:0]              tok_len;
  logic [39:0]              word_tail;
  int                       step_recs;
  int                       rec_n;
  int                       mismatch_n = 0;
  lex_rec_t                 token_records_q[$];

  assign errors_o = mismatch_n;

  function automatic logic is_num(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic void restart();
    lex_state = mlex_pkg::M_IDLE;
    cur_line  = POS_ONE;
    cur_col   = POS_ONE;
    tok_line  = POS_ONE;
    tok_col   = POS_ONE;
    tok_len   = 16'd0;
    word_tail = 40'd0;
  endfunction

  function automatic void add_rec(logic [1:0] rtype, logic [3:0] kind, logic [7:0] text,
                                  logic [POSITION_BITS-1:0] line,
                                  logic [POSITION_BITS-1:0] col,
                                  logic [15:0] len, logic [1:0] err);
    lex_rec_t r;
    r.rtype  = rtype;
    r.kind   = kind;
    r.text   = text;
    r.line   = 16'(line);
    r.column = 16'(col);
    r.length = len;
    r.err    = err;
    r.last   = 1'b0;
    if (step_recs < mlex_pkg::MAX_RECS) begin
      token_records_q.push_back(r);
      step_recs++;
    end
  endfunction

  function automatic void add_text(logic [3:0] kind, logic [7:0] c);
    if (tok_len != mlex_pkg::LEN_MAX) tok_len++;
    add_rec(mlex_pkg::REC_TEXT, kind, c, tok_line, tok_col, tok_len, ERR_NONE);
  endfunction

  function automatic void add_done(logic [3:0] kind);
    add_rec(mlex_pkg::REC_DONE, kind, 8'd0, tok_line, tok_col, tok_len, ERR_NONE);
  endfunction

  function automatic void add_fault(logic [POSITION_BITS-1:0] line,
                                    logic [POSITION_BITS-1:0] col, logic [1:0] code);
    add_rec(mlex_pkg::REC_ERROR, mlex_pkg::KIND_EOF, 8'd0, line, col, 16'd0, code);
    lex_state = mlex_pkg::M_ERROR;
  endfunction

  function automatic void open_token(mlex_pkg::mode_e m);
    lex_state = m;
    tok_line  = cur_line;
    tok_col   = cur_col;
    tok_len   = 16'd0;
  endfunction

  // only the exact words true and false get their own kinds
  function automatic logic [3:0] closing_word_kind();
    if (tok_len == 16'd4 && word_tail[31:0] == "true") return mlex_pkg::KIND_TRUE;
    if (tok_len == 16'd5 && word_tail == "false") return mlex_pkg::KIND_FALSE;
    return mlex_pkg::KIND_IDENT;
  endfunction

  function automatic void lex_idle(logic [7:0] c);
    logic [3:0] mark;
    case (c)
      "#":     mark = mlex_pkg::KIND_HASH;
      "(":     mark = mlex_pkg::KIND_LPAREN;
      ")":     mark = mlex_pkg::KIND_RPAREN;
      "{":     mark = mlex_pkg::KIND_LBRACE;
      "}":     mark = mlex_pkg::KIND_RBRACE;
      "=":     mark = mlex_pkg::KIND_EQUALS;
      default: mark = mlex_pkg::KIND_EOF;
    endcase
    if (c == " " || (c >= CH_TAB && c <= CH_CR)) return;
    if (mark != mlex_pkg::KIND_EOF) begin
      open_token(mlex_pkg::M_IDLE);
      add_text(mark, c);
      add_done(mark);
    end else if (c == "/") begin
      open_token(mlex_pkg::M_SLASH);
    end else if (c == "-") begin
      open_token(mlex_pkg::M_MINUS);
    end else if (is_num(c)) begin
      open_token(mlex_pkg::M_INT);
      add_text(mlex_pkg::KIND_INT, c);
    end else if (is_letter(c) || c == "_") begin
      open_token(mlex_pkg::M_IDENT);
      word_tail = {32'd0, c};
      add_text(mlex_pkg::KIND_IDENT, c);
    end else if (c == "\"") begin
      open_token(mlex_pkg::M_STR);
    end else begin
      add_fault(cur_line, cur_col, mlex_pkg::ERR_UNEXPECTED);
    end
  endfunction

  function automatic void lex_char(logic [7:0] c);
    logic [7:0] dec;
    dec = CH_NUL;
    case (lex_state)
      mlex_pkg::M_COMMENT: if (c == CH_LF) lex_state = mlex_pkg::M_IDLE;
      mlex_pkg::M_SLASH: begin
        if (c == "/") lex_state = mlex_pkg::M_COMMENT;
        else add_fault(tok_line, tok_col, mlex_pkg::ERR_UNEXPECTED);
      end
      mlex_pkg::M_MINUS: begin
        if (is_num(c)) begin
          lex_state = mlex_pkg::M_INT;
          add_text(mlex_pkg::KIND_INT, "-");
          add_text(mlex_pkg::KIND_INT, c);
        end else begin
          add_fault(tok_line, tok_col, mlex_pkg::ERR_UNEXPECTED);
        end
      end
      mlex_pkg::M_STR: begin
        if (c == "\"") begin
          add_done(mlex_pkg::KIND_STRING);
          lex_state = mlex_pkg::M_IDLE;
        end else if (c == "\\") begin
          lex_state = mlex_pkg::M_ESC;
        end else begin
          add_text(mlex_pkg::KIND_STRING, c);
        end
      end
      mlex_pkg::M_ESC: begin
        case (c)
          "n":        dec = CH_LF;
          "r":        dec = CH_CR;
          "t":        dec = CH_TAB;
          "\\", "\"": dec = c;
          default:    dec = CH_NUL;
        endcase
        if (dec != CH_NUL) begin
          lex_state = mlex_pkg::M_STR;
          add_text(mlex_pkg::KIND_STRING, dec);
        end else begin
          add_fault(cur_line, cur_col, mlex_pkg::ERR_ESCAPE);
        end
      end
      mlex_pkg::M_INT: begin
        if (is_num(c)) begin
          add_text(mlex_pkg::KIND_INT, c);
        end else begin
          add_done(mlex_pkg::KIND_INT);
          lex_state = mlex_pkg::M_IDLE;
          lex_idle(c);
        end
      end
      mlex_pkg::M_IDENT: begin
        if (is_letter(c) || is_num(c) || c == "_" || c == "." || c == ",") begin
          word_tail = {word_tail[31:0], c};
          add_text(mlex_pkg::KIND_IDENT, c);
        end else begin
          add_done(closing_word_kind());
          lex_state = mlex_pkg::M_IDLE;
          lex_idle(c);
        end
      end
      mlex_pkg::M_IDLE: lex_idle(c);
      default: lex_state = mlex_pkg::M_ERROR;
    endcase
  endfunction

  function automatic void lex_finish();
    if (lex_state == mlex_pkg::M_IDENT) add_done(closing_word_kind());
    if (lex_state == mlex_pkg::M_INT) add_done(mlex_pkg::KIND_INT);
    case (lex_state)
      mlex_pkg::M_SLASH, mlex_pkg::M_MINUS:
        add_fault(tok_line, tok_col, mlex_pkg::ERR_UNEXPECTED);
      mlex_pkg::M_STR, mlex_pkg::M_ESC:
        add_fault(tok_line, tok_col, mlex_pkg::ERR_UNTERM);
      mlex_pkg::M_ERROR: ;
      default:
        add_rec(mlex_pkg::REC_DONE, mlex_pkg::KIND_EOF, 8'd0, cur_line, cur_col, 16'd0,
                ERR_NONE);
    endcase
  endfunction

  function automatic void lex_source_byte(logic [7:0] c, logic eot);
    int       first;
    lex_rec_t tail;
    first     = token_records_q.size();
    step_recs = 0;
    if (eot || c == CH_NUL) begin
      lex_finish();
      restart();
    end else if (lex_state != mlex_pkg::M_ERROR) begin
      lex_char(c);
      if (c == CH_LF) begin
        if (cur_line != POS_SAT) cur_line++;
        cur_col = POS_ONE;
      end else if (cur_col != POS_SAT) begin
        cur_col++;
      end
    end
    if (token_records_q.size() > first) begin
      tail = token_records_q.pop_back();
      tail.last = 1'b1;
      token_records_q.push_back(tail);
    end
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_n++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("record %0d %s: got %0d, expected %0d", rec_n, name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lex_rec_t got;
    lex_rec_t want;
    if (!rst_ni) begin
      restart();
      token_records_q.delete();
      rec_n = 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) lex_source_byte(char_byte_i, end_of_text_i);
      if (out_valid_i && !out_stall_i) begin
        got = {record_type_i, token_kind_i, text_byte_i, start_line_i, start_column_i,
               text_length_i, error_code_i, last_i};
        if (token_records_q.size() == 0) begin
          report_mismatch($sformatf("record %0d with nothing pending: type %0d kind %0d",
                                    rec_n, got.rtype, got.kind));
        end else begin
          want = token_records_q.pop_front();
          compare_field("record_type", 16'(got.rtype), 16'(want.rtype));
          compare_field("token_kind", 16'(got.kind), 16'(want.kind));
          compare_field("text_byte", 16'(got.text), 16'(want.text));
          compare_field("start_line", got.line, want.line);
          compare_field("start_column", got.column, want.column);
          compare_field("text_length", got.length, want.length);
          compare_field("error_code", 16'(got.err), 16'(want.err));
          compare_field("last", 16'(got.last), 16'(want.last));
        end
        rec_n++;
      end
      pending_o <= token_records_q.size();
    end
  end

endmodule

### bench/markup_lexer_top_test.sv
// markup lexer testbench top: clock, reset, source byte stimulus with random
// idling on both channels, and the verdict
// depends on mlex_pkg, markup_lexer_top and markup_lexer_checker
`timescale 1ns / 1ps
module markup_lexer_top_test;
  localparam int POS_BITS = mlex_pkg::POSITION_BITS_DEF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_byte = 8'd0;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  record_type;
  logic [3:0]  token_kind;
  logic [7:0]  text_byte;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [15:0] text_length;
  logic [1:0]  error_code;
  logic        last;
  int          pending;
  int          errors;

  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;
  int          stall_left = 0;
  int          src_bytes = 0;
  logic [7:0]  doc_q[$];
  string       word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789.,";
  string       marks = "#(){}=";

  markup_lexer_top #(
    .POSITION_BITS(POS_BITS)
  ) u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .char_byte_i   (char_byte),
    .end_of_text_i (end_of_text),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .record_type_o (record_type),
    .token_kind_o  (token_kind),
    .text_byte_o   (text_byte),
    .start_line_o  (start_line),
    .start_column_o(start_column),
    .text_length_o (text_length),
    .error_code_o  (error_code),
    .last_o        (last)
  );

  markup_lexer_checker #(
    .POSITION_BITS(POS_BITS)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .char_byte_i   (char_byte),
    .end_of_text_i (end_of_text),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .record_type_i (record_type),
    .token_kind_i  (token_kind),
    .text_byte_i   (text_byte),
    .start_line_i  (start_line),
    .start_column_i(start_column),
    .text_length_i (text_length),
    .error_code_i  (error_code),
    .last_i        (last),
    .pending_o     (pending),
    .errors_o      (errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= idle_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #10_000_000;
    $display("** markup_lexer_top: FAILED **");
    $finish;
  end

  function automatic void put_src(string s);
    foreach (s[i]) doc_q.push_back(s[i]);
  endfunction

  function automatic void put_word_char(int hi);
    doc_q.push_back(word_chars[$urandom_range(0, hi)]);
  endfunction

  task automatic send_word(input logic [7:0] ch, input logic eot);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(negedge clk);
    end
    in_valid    <= 1'b1;
    char_byte   <= ch;
    end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // one source text, closed by either form of the end marker
  task automatic send_doc();
    foreach (doc_q[i]) send_word(doc_q[i], 1'b0);
    if ($urandom_range(0, 1) == 1) send_word(8'($urandom_range(0, 255)), 1'b1);
    else send_word(8'd0, 1'b0);
    src_bytes += doc_q.size() + 1;
    doc_q.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic void add_random_token();
    int         pick;
    logic [7:0] ch;
    case ($urandom_range(0, 7))
      0:       put_src("\n");
      1:       put_src("\t");
      2:       put_src(" // x\n");
      3, 4:    ;
      default: put_src(" ");
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      doc_q.push_back(marks[$urandom_range(0, 5)]);
    end else if (pick < 45) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0:       put_src("true");
          1:       put_src("false");
          2:       put_src("truex");
          3:       put_src("fals");
          default: put_src("t");
        endcase
      end else begin
        put_word_char(52);
        repeat ($urandom_range(0, 7)) put_word_char(64);
      end
    end else if (pick < 65) begin
      if ($urandom_range(0, 2) == 0) put_src("-");
      repeat ($urandom_range(1, 6)) doc_q.push_back(8'($urandom_range(48, 57)));
    end else if (pick < 85) begin
      put_src("\"");
      repeat ($urandom_range(0, 8)) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 4))
            0:       put_src("\\n");
            1:       put_src("\\r");
            2:       put_src("\\t");
            3:       put_src("\\\\");
            default: put_src("\\\"");
          endcase
        end else begin
          ch = 8'($urandom_range(1, 255));
          if (ch == "\"" || ch == "\\") ch = "q";
          doc_q.push_back(ch);
        end
      end
      put_src("\"");
    end else if (pick < 92) begin
      put_src("//");
      repeat ($urandom_range(0, 8)) begin
        ch = 8'($urandom_range(1, 255));
        doc_q.push_back(ch == 8'h0a ? 8'h20 : ch);
      end
      put_src("\n");
    end else begin
      case ($urandom_range(0, 4))
        0:       doc_q.push_back(8'($urandom_range(1, 255)));
        1:       put_src("/");
        2:       put_src("-");
        3:       put_src("\"x\\");
        default: put_src("\"open ");
      endcase
      doc_q.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    gaps_on = 1'b1;
    stalls_on = 1'b1;
    put_src("#(){}=");
    send_doc();
    put_src("true false truex t fals _a.b,c9 Zz");
    send_doc();
    put_src("0 9 -42 12# ab( -x 7");
    send_doc();
    put_src("\"a\\n\\r\\t\\\\\\\"b\" \"\"");
    send_doc();
    put_src("// note } \n= x/y");
    send_doc();
    put_src("\"ab\\q\" skipped");
    send_doc();
    put_src("\"abc");
    send_doc();
    put_src("\"ab\\");
    send_doc();
    put_src("a ");
    doc_q.push_back(8'hff);
    send_doc();
    doc_q.push_back(8'h80);
    send_doc();
    put_src("  \n\t");
    doc_q.push_back(8'h0b);
    doc_q.push_back(8'h0c);
    put_src("\r  x");
    send_doc();
    put_src("-");
    send_doc();
    put_src("/");
    send_doc();
    send_doc();
    put_src("12");
    send_doc();
    put_src("false");
    send_doc();
    put_src("{ @ }");
    send_doc();
    wait_drained();

    while (src_bytes < 450) begin
      gaps_on = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(1, 6)) add_random_token();
      send_doc();
      if ($urandom_range(0, 4) == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) $display("** markup_lexer_top: PASSED **");
    else $display("** markup_lexer_top: FAILED **");
    $finish;
  end

endmodule
